FILE: sv/line_path_yaw_window_generator_defines.svh
// Assertion helpers included by the lpyw_checker module.
`ifndef LINE_PATH_YAW_WINDOW_GENERATOR_DEFINES_SVH
`define LINE_PATH_YAW_WINDOW_GENERATOR_DEFINES_SVH

// checked only outside reset
`define LPYW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("lpyw check failed");

// checked in every cycle, reset included
`define LPYW_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("lpyw reset check failed");

`endif

FILE: sv/lpyw_pkg.sv
package lpyw_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PI_Q       = 12868;
  localparam int TWO_PI_Q   = 25736;

  // divider: 56-bit dividend, 40-bit divisor
  localparam int DIV_N_W = 56;
  localparam int DIV_D_W = 40;
  // square root: 66-bit radicand, 33-bit root
  localparam int SQ_IN_W  = 66;
  localparam int SQ_OUT_W = 33;

  localparam logic [1:0] REG_START_DIST = 2'd0;
  localparam logic [1:0] REG_END_DIST   = 2'd1;
  localparam logic [1:0] REG_CLOCKWISE  = 2'd2;
  localparam logic [1:0] REG_POINTS     = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_WRAP,
    ST_WIN,
    ST_MWS,
    ST_MLWE,
    ST_MMID,
    ST_MLD,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_DLD_GO,
    ST_DLD_WAIT,
    ST_POSE,
    ST_RMUL,
    ST_RDIV_GO,
    ST_RDIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_res_t;

endpackage

FILE: sv/lpyw_div.sv
// Restoring divider, one quotient bit per cycle.
module lpyw_div (
  input  logic              clk,
  input  logic              rst,
  input  lpyw_pkg::div_req_t req,
  output lpyw_pkg::div_res_t res
);
  import lpyw_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   rem_t;
  logic               fits;

  assign rem_t = {rem, dvd[DIV_N_W-1]};
  assign fits  = rem_t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_D_W'(rem_t - {1'b0, dvs});
      end else begin
        rem <= rem_t[DIV_D_W-1:0];
      end
      dvd <= {dvd[DIV_N_W-2:0], fits};
    end
  end

  assign res.done = done;
  assign res.quot = dvd;
  assign res.rem  = rem;

endmodule

FILE: sv/lpyw_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module lpyw_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  lpyw_pkg::sqrt_req_t req,
  output lpyw_pkg::sqrt_res_t res
);
  import lpyw_pkg::*;

  localparam int CNT_W = $clog2(SQ_OUT_W);
  localparam int REM_W = SQ_OUT_W + 3;

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [SQ_IN_W-1:0]  rad;
  logic [REM_W-1:0]    rem;
  logic [SQ_OUT_W-1:0] root;
  logic [REM_W-1:0]    rem_t;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // remainder stays below 2*root + 1, so its top bits are free
  assign rem_t = {rem[REM_W-3:0], rad[SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_t - trial : rem_t;
      root <= {root[SQ_OUT_W-2:0], fits};
      rad  <= {rad[SQ_IN_W-3:0], 2'b00};
    end
  end

  assign res.done = done;
  assign res.root = root;

endmodule

FILE: sv/line_path_yaw_window_generator.sv
// An accepted request runs two squares, a 33-step square root, a yaw wrap loop, four
// window multiplies and three 56-step divisions before the first pose. Each further pose
// passes through ST_POSE and ST_OUT and can be held by output stall; the first pose inside the
// yaw ramp adds one multiply and one 56-step division.
// A new request is taken only in ST_IDLE, after the last pose of the previous path is accepted.
// Reset (rst, synchronous): sequencer idle, no pose pending, registers to 0, 0, 0, 64.
module line_path_yaw_window_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_yaw, goal_x_pos, goal_y_pos, goal_heading, zero fill
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pose_x, pose_y, pose_yaw, zero fill
  output logic [87:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import lpyw_pkg::*;

  state_t state, state_next;

  logic signed [31:0] rotate_start_dist;
  logic signed [31:0] rotate_end_dist;
  logic               turn_clockwise;
  logic [6:0]         point_count;

  logic signed [31:0] sx, sy;
  logic signed [17:0] syaw;
  logic               dx_neg, dy_neg;
  logic [31:0]        ax, ay;
  logic signed [18:0] ang;
  logic               delta_neg;
  logic [14:0]        dmag;
  logic [5:0]         m;
  logic [63:0]        sqx;
  logic [32:0]        len;
  logic [30:0]        ws;
  logic [32:0]        lenwe, mid;
  logic               mid_zero;
  logic [36:0]        wsm;
  logic [38:0]        lwem, dd;
  logic [47:0]        ld;
  logic [31:0]        xq, xstep, yq_pos, ystep;
  logic [5:0]         xr, xrstep, yr_pos, yrstep;
  logic [16:0]        aq, astep;
  logic [38:0]        ar, arstep;
  logic [38:0]        s_acc;
  logic [5:0]         idx;
  logic               ramp_ok;
  logic [63:0]        prod;

  logic [38:0] mul_a;
  logic [31:0] mul_b;
  logic [70:0] mul_p;

  div_req_t  dreq;
  div_res_t  dres;
  sqrt_req_t sreq;
  sqrt_res_t sres;

  lpyw_div u_div (.clk(clk), .rst(rst), .req(dreq), .res(dres));
  lpyw_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sreq), .res(sres));

  // request decode
  logic signed [32:0] in_dx, in_dy;
  logic [32:0]        in_ax, in_ay;
  logic [6:0]         n_clamp;
  assign in_dx = {s_tdata[113], s_tdata[113:82]} - {s_tdata[31], s_tdata[31:0]};
  assign in_dy = {s_tdata[145], s_tdata[145:114]} - {s_tdata[63], s_tdata[63:32]};
  assign in_ax = in_dx[32] ? -in_dx : in_dx;
  assign in_ay = in_dy[32] ? -in_dy : in_dy;
  assign n_clamp = (point_count < 7'd2) ? 7'd2 :
                   (point_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count;

  // window clamp
  logic [30:0] ws_c, we_c, ws_e, we_e;
  logic [31:0] win_sum;
  logic        too_big;
  logic [32:0] lenwe_c;
  assign ws_c    = (rotate_start_dist > 0) ? rotate_start_dist[30:0] : '0;
  assign we_c    = (rotate_end_dist > 0) ? rotate_end_dist[30:0] : '0;
  assign win_sum = {1'b0, ws_c} + {1'b0, we_c};
  assign too_big = {1'b0, win_sum} >= len;
  assign ws_e    = too_big ? '0 : ws_c;
  assign we_e    = too_big ? '0 : we_c;
  assign lenwe_c = len - {2'b0, we_e};

  // yaw wrap
  logic ang_hi, ang_lo;
  logic signed [18:0] delta_c;
  assign ang_hi = ang > 19'sd12868;
  assign ang_lo = ang < -19'sd12868;
  always_comb begin
    if (turn_clockwise) begin
      delta_c = (ang > 0) ? ang - 19'(TWO_PI_Q) : ang;
    end else begin
      delta_c = (ang < 0) ? ang + 19'(TWO_PI_Q) : ang;
    end
  end

  // pose evaluation
  logic        hold_start, hold_end;
  logic [38:0] num;
  logic signed [19:0] yaw_off, yaw_sum;
  logic signed [17:0] yaw_sat;
  logic signed [31:0] pose_x_c, pose_y_c;
  assign num        = s_acc - {2'b0, wsm};
  assign hold_start = (s_acc <= {2'b0, wsm}) || mid_zero;
  assign hold_end   = s_acc >= lwem;
  always_comb begin
    if (hold_start) begin
      yaw_off = '0;
    end else if (hold_end) begin
      yaw_off = delta_neg ? -$signed({5'b0, dmag}) : $signed({5'b0, dmag});
    end else begin
      yaw_off = delta_neg ? -$signed({3'b0, aq}) : $signed({3'b0, aq});
    end
  end
  assign yaw_sum = {{2{syaw[17]}}, syaw} + yaw_off;
  always_comb begin
    if (yaw_sum > 20'sd131071) begin
      yaw_sat = 18'sd131071;
    end else if (yaw_sum < -20'sd131072) begin
      yaw_sat = -18'sd131072;
    end else begin
      yaw_sat = yaw_sum[17:0];
    end
  end
  assign pose_x_c = sx + (dx_neg ? -xq : xq);
  assign pose_y_c = sy + (dy_neg ? -yq_pos : yq_pos);

  // shared multiplier
  always_comb begin
    unique case (state)
      ST_SQX:  begin mul_a = {7'b0, ax};   mul_b = ax;            end
      ST_SQY:  begin mul_a = {7'b0, ay};   mul_b = ay;            end
      ST_MWS:  begin mul_a = {8'b0, ws};   mul_b = {26'b0, m};    end
      ST_MLWE: begin mul_a = {6'b0, lenwe}; mul_b = {26'b0, m};   end
      ST_MMID: begin mul_a = {6'b0, mid};  mul_b = {26'b0, m};    end
      ST_MLD:  begin mul_a = {6'b0, len};  mul_b = {17'b0, dmag}; end
      ST_RMUL: begin mul_a = num;          mul_b = {17'b0, dmag}; end
      default: begin mul_a = '0;           mul_b = '0;            end
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {39'b0, mul_b};

  always_ff @(posedge clk) begin
    prod <= mul_p[63:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    sreq.start    = 1'b0;
    sreq.radicand = {2'b0, sqx} + {2'b0, prod};
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_SQX;
      end
      ST_SQX:       state_next = ST_SQY;
      ST_SQY:       state_next = ST_SQRT_GO;
      ST_SQRT_GO: begin
        sreq.start = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (sres.done) state_next = ST_WRAP;
      ST_WRAP:      if (!ang_hi && !ang_lo) state_next = ST_WIN;
      ST_WIN:       state_next = ST_MWS;
      ST_MWS:       state_next = ST_MLWE;
      ST_MLWE:      state_next = ST_MMID;
      ST_MMID:      state_next = ST_MLD;
      ST_MLD:       state_next = ST_DX_GO;
      ST_DX_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {24'b0, ax};
        dreq.divisor  = {34'b0, m};
        state_next    = ST_DX_WAIT;
      end
      ST_DX_WAIT:   if (dres.done) state_next = ST_DY_GO;
      ST_DY_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {24'b0, ay};
        dreq.divisor  = {34'b0, m};
        state_next    = ST_DY_WAIT;
      end
      ST_DY_WAIT:   if (dres.done) state_next = ST_DLD_GO;
      ST_DLD_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {8'b0, ld};
        dreq.divisor  = {1'b0, dd};
        state_next    = ST_DLD_WAIT;
      end
      ST_DLD_WAIT:  if (dres.done) state_next = ST_POSE;
      ST_POSE: begin
        if (!hold_start && !hold_end && !ramp_ok) begin
          state_next = ST_RMUL;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_RMUL:      state_next = ST_RDIV_GO;
      ST_RDIV_GO: begin
        // rounding: add half the divisor, ties go away from zero
        dreq.start    = 1'b1;
        dreq.dividend = {2'b0, prod[53:0]} + {17'b0, dd[38:1]};
        dreq.divisor  = {1'b0, dd};
        state_next    = ST_RDIV_WAIT;
      end
      ST_RDIV_WAIT: if (dres.done) state_next = ST_POSE;
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = m_tlast ? ST_IDLE : ST_POSE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_start_dist <= '0;
      rotate_end_dist   <= '0;
      turn_clockwise    <= 1'b0;
      point_count       <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_DIST: rotate_start_dist <= cfg_data;
        REG_END_DIST:   rotate_end_dist   <= cfg_data;
        REG_CLOCKWISE:  turn_clockwise    <= cfg_data[0];
        REG_POINTS:     point_count       <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  // datapath
  logic [6:0]  xsum, ysum;
  logic [39:0] asum;
  assign xsum = {1'b0, xr} + {1'b0, xrstep};
  assign ysum = {1'b0, yr_pos} + {1'b0, yrstep};
  assign asum = {1'b0, ar} + {1'b0, arstep};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sx     <= s_tdata[31:0];
        sy     <= s_tdata[63:32];
        syaw   <= s_tdata[81:64];
        dx_neg <= in_dx[32];
        dy_neg <= in_dy[32];
        ax     <= in_ax[31:0];
        ay     <= in_ay[31:0];
        ang    <= {s_tdata[163], s_tdata[163:146]} - {s_tdata[81], s_tdata[81:64]};
        m      <= 6'(n_clamp - 7'd1);
      end
      ST_SQY:       sqx <= prod;
      ST_SQRT_WAIT: if (sres.done) len <= sres.root;
      ST_WRAP: begin
        if (ang_hi) begin
          ang <= ang - 19'(TWO_PI_Q);
        end else if (ang_lo) begin
          ang <= ang + 19'(TWO_PI_Q);
        end else begin
          delta_neg <= delta_c[18];
          dmag      <= delta_c[18] ? 15'(-delta_c) : delta_c[14:0];
        end
      end
      ST_WIN: begin
        ws       <= ws_e;
        lenwe    <= lenwe_c;
        mid      <= lenwe_c - {2'b0, ws_e};
        mid_zero <= (lenwe_c == {2'b0, ws_e});
      end
      ST_MLWE:  wsm  <= prod[36:0];
      ST_MMID:  lwem <= prod[38:0];
      ST_MLD:   dd   <= prod[38:0];
      ST_DX_GO: ld   <= prod[47:0];
      ST_DX_WAIT: if (dres.done) begin
        xstep  <= dres.quot[31:0];
        xrstep <= dres.rem[5:0];
      end
      ST_DY_WAIT: if (dres.done) begin
        ystep  <= dres.quot[31:0];
        yrstep <= dres.rem[5:0];
      end
      ST_DLD_WAIT: if (dres.done) begin
        // only the low quotient bits matter: ramp yaw stays within one turn
        astep   <= dres.quot[16:0];
        arstep  <= dres.rem[38:0];
        xq      <= '0;
        yq_pos  <= '0;
        xr      <= m >> 1;
        yr_pos  <= m >> 1;
        s_acc   <= '0;
        idx     <= '0;
        ramp_ok <= 1'b0;
      end
      ST_RDIV_WAIT: if (dres.done) begin
        aq      <= dres.quot[16:0];
        ar      <= dres.rem[38:0];
        ramp_ok <= 1'b1;
      end
      ST_POSE: begin
        m_tdata <= {6'b0, yaw_sat, pose_y_c, pose_x_c};
        m_tlast <= (idx == m);
      end
      ST_OUT: if (m_tready) begin
        idx   <= idx + 1'b1;
        s_acc <= s_acc + {6'b0, len};
        if (xsum >= {1'b0, m}) begin
          xr <= 6'(xsum - {1'b0, m});
          xq <= xq + xstep + 32'd1;
        end else begin
          xr <= xsum[5:0];
          xq <= xq + xstep;
        end
        if (ysum >= {1'b0, m}) begin
          yr_pos <= 6'(ysum - {1'b0, m});
          yq_pos <= yq_pos + ystep + 32'd1;
        end else begin
          yr_pos <= ysum[5:0];
          yq_pos <= yq_pos + ystep;
        end
        if (ramp_ok) begin
          if (asum >= {1'b0, dd}) begin
            ar <= 39'(asum - {1'b0, dd});
            aq <= aq + astep + 17'd1;
          end else begin
            ar <= asum[38:0];
            aq <= aq + astep;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/lpyw_checker.sv
`include "line_path_yaw_window_generator_defines.svh"

module lpyw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tlast
);

  // one request at a time: never open for input while a pose waits
  `LPYW_ASSERT(a_no_overlap, !(s_tready && m_tvalid))
  `LPYW_ASSERT(a_busy_after_req, (s_tvalid && s_tready) |=> !s_tready)
  `LPYW_ASSERT(a_hold_stalled, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
  `LPYW_ASSERT(a_idle_after_last, (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
  `LPYW_ASSERT_RST(a_reset_quiet, rst |=> !m_tvalid)

endmodule

bind line_path_yaw_window_generator lpyw_checker u_lpyw_checker (.*);

FILE: dv/path_checker.sv
`timescale 1ns / 1ps
module path_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [87:0]  m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           poses_pending
);
  import lpyw_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [17:0] yaw;
    logic               last;
  } pose_t;

  pose_t pose_q[$];
  longint win_start, win_end;
  bit     cw;
  int     npts;

  assign poses_pending = pose_q.size();

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // exact integer square root of a sum of squares up to 2^65
  function automatic longint path_length(longint ax, longint ay);
    logic [65:0] sum, c2;
    logic [32:0] r, c;
    sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    r = 0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      c2 = 66'(c) * 66'(c);
      if (c2 <= sum) r = c;
    end
    return longint'(r);
  endfunction

  task automatic predict_path(logic [167:0] d);
    longint sx, sy, sya, gx, gy, gya, dx, dy, len, n, m, a, dl, ws, we, mid, s, yaw;
    pose_t p;
    sx = longint'($signed(d[31:0]));
    sy = longint'($signed(d[63:32]));
    sya = longint'($signed(d[81:64]));
    gx = longint'($signed(d[113:82]));
    gy = longint'($signed(d[145:114]));
    gya = longint'($signed(d[163:146]));
    dx = gx - sx;
    dy = gy - sy;
    len = path_length(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
    n = npts < 2 ? 2 : (npts > MAX_POINTS ? MAX_POINTS : npts);
    m = n - 1;
    a = gya - sya;
    while (a > PI_Q) a -= TWO_PI_Q;
    while (a < -PI_Q) a += TWO_PI_Q;
    if (cw) dl = (a > 0) ? a - TWO_PI_Q : a;
    else dl = (a < 0) ? a + TWO_PI_Q : a;
    ws = win_start > 0 ? win_start : 0;
    we = win_end > 0 ? win_end : 0;
    if (ws + we >= len) begin
      ws = 0;
      we = 0;
    end
    mid = len - ws - we;
    for (longint i = 0; i < n; i++) begin
      s = i * len;
      if (s <= ws * m || mid == 0) yaw = sya;
      else if (s >= (len - we) * m) yaw = sya + dl;
      else yaw = sya + round_div((s - ws * m) * dl, mid * m);
      if (yaw > 131071) yaw = 131071;
      if (yaw < -131072) yaw = -131072;
      p.x = 32'(sx + round_div(i * dx, m));
      p.y = 32'(sy + round_div(i * dy, m));
      p.yaw = 18'(yaw);
      p.last = (i == m);
      pose_q.insert(pose_q.size(), p);
    end
  endtask

  always @(posedge clk) begin
    pose_t e;
    int    errs;
    if (rst) begin
      win_start <= 0;
      win_end <= 0;
      cw <= 0;
      npts <= 64;
      fail_count <= 0;
      pose_q.delete();
    end else begin
      errs = 0;
      if (cfg_we) begin
        case (cfg_index)
          REG_START_DIST: win_start <= longint'($signed(cfg_data));
          REG_END_DIST:   win_end <= longint'($signed(cfg_data));
          REG_CLOCKWISE:  cw <= cfg_data[0];
          REG_POINTS:     npts <= int'(cfg_data[6:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_path(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pose_q.size() == 0) begin
          $error("unexpected pose %h", m_tdata);
          errs++;
        end else begin
          e = pose_q.pop_front();
          if (m_tdata[31:0] !== e.x) begin
            $error("pose_x expected %h actual %h", e.x, m_tdata[31:0]);
            errs++;
          end
          if (m_tdata[63:32] !== e.y) begin
            $error("pose_y expected %h actual %h", e.y, m_tdata[63:32]);
            errs++;
          end
          if (m_tdata[81:64] !== e.yaw) begin
            $error("pose_yaw expected %h actual %h", e.yaw, m_tdata[81:64]);
            errs++;
          end
          if (m_tlast !== e.last) begin
            $error("last_point expected %b actual %b", e.last, m_tlast);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lpyw_pkg::*;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [167:0] s_tdata;
  logic [87:0]  m_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count, poses_pending;
  bit           calm, hold_off;

  line_path_yaw_window_generator DUT (.*);
  path_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, unless calm; a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !hold_off && (calm || $urandom_range(99) >= 20);
  end

  function automatic logic [31:0] rand_pos(bit near);
    if (near) return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    case ($urandom_range(3))
      0: return $urandom;
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic logic [17:0] rand_yaw();
    if ($urandom_range(3) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // leaves s_tvalid high after the accepting edge; drain, or a random pause in the next call, lowers it
  task automatic send_path(logic [31:0] sx, sy, logic [17:0] sya,
                           logic [31:0] gx, gy, logic [17:0] gya);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'd0, gya, gy, gx, sya, sy, sx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (poses_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] ws, we, bit cwise, logic [6:0] n);
    write_reg(REG_START_DIST, ws);
    write_reg(REG_END_DIST, we);
    write_reg(REG_CLOCKWISE, 32'(cwise));
    write_reg(REG_POINTS, 32'(n));
    cfg_we <= 0;
  endtask

  initial begin
    s_tvalid = 0;
    s_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    calm = 0;
    hold_off = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset settings: 64 points, no windows
    send_path(0, 0, 0, 32'h000A0000, 32'h00050000, 18'd6000);
    send_path(32'h80000000, 32'h80000000, 18'h20000, 32'h7FFFFFFF, 32'h7FFFFFFF, 18'h1FFFF);
    drain();
    set_regs(32'h00020000, 32'h00030000, 1, 0);
    send_path(0, 0, 18'd12868, 0, 0, -18'sd12868);          // zero length
    send_path(0, 0, 0, 32'h00100000, 0, 18'd100);
    send_path(32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h00000001, 18'h1FFFF);
    drain();
    set_regs(32'h80000000, 32'hFFFF0000, 0, 127);           // negative windows, count saturates
    send_path(0, 0, -18'sd100, 32'h00030000, 32'h00040000, 18'd100);
    send_path(0, 0, 18'd131000, 32'h00030000, 0, -18'sd131000);
    drain();
    set_regs(32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1);            // windows exceed length
    send_path(0, 0, -18'sd131072, 32'h00010000, 0, 18'd131071);
    drain();
    set_regs(32'h00040000, 32'h00040000, 0, 3);             // empty middle segment
    send_path(0, 0, 0, 32'h00080000, 0, 18'd3000);
    send_path(0, 0, 0, 32'h00090000, 0, 18'd3000);
    drain();
    // back-pressure: hold the receiver while requests keep coming
    set_regs(0, 0, 0, 64);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        repeat (4) send_path(rand_pos(1), rand_pos(1), rand_yaw(), rand_pos(1), rand_pos(1),
                             rand_yaw());
        drain();
      end
    join
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4);
      set_regs(($urandom_range(3) == 0) ? $urandom : $urandom_range(8 << 16),
               ($urandom_range(3) == 0) ? $urandom : $urandom_range(8 << 16),
               1'($urandom_range(1)),
               (ph == 9) ? 7'd64 : 7'($urandom_range((ph % 3 == 0) ? 127 : 10)));
      repeat (48) begin
        bit near;
        near = 1'($urandom_range(1));
        send_path(rand_pos(near), rand_pos(near), rand_yaw(),
                  rand_pos(near), rand_pos(near), rand_yaw());
      end
      drain();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: line_path_yaw_window_generator.f
+incdir+sv
sv/lpyw_pkg.sv
sv/lpyw_div.sv
sv/lpyw_sqrt.sv
sv/line_path_yaw_window_generator.sv
sv/lpyw_checker.sv
dv/path_checker.sv
dv/testbench.sv
